// ----- design/psfc_pkg.sv -----
// Shared types, constants and helpers of the particle sensor frame checker.
`default_nettype none

package psfc_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0]  START_BYTE_ONE    = 8'h42;
  localparam logic [7:0]  START_BYTE_TWO    = 8'h4D;
  localparam logic [15:0] FRAME_LENGTH_CODE = 16'(2 * 13 + 2);
  localparam logic [POS_W-1:0] SUMMED_BYTES = POS_W'(28);

  // Frame byte positions
  localparam logic [POS_W-1:0] POS_START_ONE = POS_W'(0);
  localparam logic [POS_W-1:0] POS_START_TWO = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN_HI    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PM1_LO    = POS_W'(4);
  localparam logic [POS_W-1:0] POS_PM1_HI    = POS_W'(5);
  localparam logic [POS_W-1:0] POS_PM25_LO   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_PM25_HI   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_PM10_LO   = POS_W'(8);
  localparam logic [POS_W-1:0] POS_PM10_HI   = POS_W'(9);
  localparam logic [POS_W-1:0] POS_CHECK_LO  = POS_W'(30);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_START  = 2'd1,
    ST_BAD_LENGTH = 2'd2,
    ST_BAD_CHECK  = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] pm1_standard;
    logic [15:0] pm25_std;
    logic [15:0] pm10_std;
    logic [15:0] received_check;
    logic [15:0] expected_check;
  } frame_result_t;

  // Place a byte in the low or high half of a word.
  function automatic logic [15:0] put_byte(input logic [15:0] word, input logic high_half,
                                           input logic [7:0] b);
    put_byte = high_half ? {b, word[7:0]} : {word[15:8], b};
  endfunction

endpackage

`default_nettype wire

// ----- design/psfc_frame_acc.sv -----
// Frame accumulator: byte position, running checksum, captured words and verdict logic.
`default_nettype none

module psfc_frame_acc
  import psfc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_en,
  input  wire logic [7:0]    byte_in,
  output logic               frame_last,
  output frame_result_t      result
);

  logic [POS_W-1:0] pos_r,   pos_nxt;
  logic [15:0]      sum_r,   sum_nxt;
  logic             start_good_r, start_good_nxt;
  logic [15:0]      len_r,   len_nxt;
  logic [15:0]      pm1_r,   pm1_nxt;
  logic [15:0]      pm25_r,  pm25_nxt;
  logic [15:0]      pm10_r,  pm10_nxt;
  logic [7:0]       chk_lo_r, chk_lo_nxt;
  logic [15:0]      received;

  assign frame_last = (pos_r == POS_LAST);
  assign received   = {byte_in, chk_lo_r};

  always_comb begin
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    start_good_nxt = start_good_r;
    len_nxt        = len_r;
    pm1_nxt        = pm1_r;
    pm25_nxt       = pm25_r;
    pm10_nxt       = pm10_r;
    chk_lo_nxt     = chk_lo_r;
    if (byte_en) begin
      if (pos_r < SUMMED_BYTES) begin
        sum_nxt = sum_r + {8'd0, byte_in};
      end
      case (pos_r)
        POS_START_ONE: start_good_nxt = (byte_in == START_BYTE_ONE);
        POS_START_TWO: start_good_nxt = start_good_r && (byte_in == START_BYTE_TWO);
        POS_LEN_LO, POS_LEN_HI:   len_nxt  = put_byte(len_r,  pos_r[0], byte_in);
        POS_PM1_LO, POS_PM1_HI:   pm1_nxt  = put_byte(pm1_r,  pos_r[0], byte_in);
        POS_PM25_LO, POS_PM25_HI: pm25_nxt = put_byte(pm25_r, pos_r[0], byte_in);
        POS_PM10_LO, POS_PM10_HI: pm10_nxt = put_byte(pm10_r, pos_r[0], byte_in);
        POS_CHECK_LO:             chk_lo_nxt = byte_in;
        default: ;
      endcase
      if (frame_last) begin
        // restart the frame
        pos_nxt        = '0;
        sum_nxt        = '0;
        start_good_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_comb begin
    result.pm1_standard   = pm1_r;
    result.pm25_std       = pm25_r;
    result.pm10_std       = pm10_r;
    result.received_check = received;
    result.expected_check = sum_r;
    if (!start_good_r) begin
      result.status = ST_BAD_START;
    end else if (len_r != FRAME_LENGTH_CODE) begin
      result.status = ST_BAD_LENGTH;
    end else if (received != sum_r) begin
      result.status = ST_BAD_CHECK;
    end else begin
      result.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      sum_r        <= '0;
      start_good_r <= 1'b0;
      len_r        <= '0;
      pm1_r        <= '0;
      pm25_r       <= '0;
      pm10_r       <= '0;
      chk_lo_r     <= '0;
    end else begin
      pos_r        <= pos_nxt;
      sum_r        <= sum_nxt;
      start_good_r <= start_good_nxt;
      len_r        <= len_nxt;
      pm1_r        <= pm1_nxt;
      pm25_r       <= pm25_nxt;
      pm10_r       <= pm10_nxt;
      chk_lo_r     <= chk_lo_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/particle_sensor_frame_checker.sv -----
// Top level of the particle sensor frame checker: input stage, accumulator and result register.
`default_nettype none

// Takes a particle sensor stream one byte per transfer and treats every 32 bytes as one
// frame, with no resynchronization. Words are little endian. On the last byte of each frame
// one result transfer carries the verdict (bad start bytes, then a length word other than 28,
// then a checksum mismatch, else ok), the PM1.0, PM2.5 and PM10 standard words, the checksum
// word from the frame and the 16-bit sum of bytes 0 to 27. Every other byte gives no result.
// A byte is held in the input register and then folded into the frame state; a frame's
// result is captured in the result register when its last byte leaves the input register.
// Throughput is one byte per cycle while the input does not stall; the input
// stalls only while a finished result sits unaccepted in the output register and the next
// last-of-frame byte wants to replace it.
module particle_sensor_frame_checker
  import psfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_frame_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [15:0]      out_pm1_standard,
  output logic [15:0]      out_pm25_std,
  output logic [15:0]      out_pm10_std,
  output logic [15:0]      out_received_check,
  output logic [15:0]      out_expected_check
);

  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_byte_r;
  logic          s1_adv;
  logic          out_free;
  logic          acc_last;
  frame_result_t acc_result;
  logic          out_valid_r, out_valid_nxt;
  frame_result_t out_res_r;
  logic          load_result;

  // Result register is free when empty or being taken in this cycle.
  assign out_free    = !out_valid_r || !out_stall;
  // Advance the held byte unless it closes a frame and the result register is still full.
  assign s1_adv      = s1_valid_r && (!acc_last || out_free);
  assign in_stall    = s1_valid_r && !s1_adv;
  assign load_result = s1_adv && acc_last;

  psfc_frame_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (s1_adv),
    .byte_in    (s1_byte_r),
    .frame_last (acc_last),
    .result     (acc_result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: hold unless a new transfer lands.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_frame_byte;
    end
    if (load_result) begin
      out_res_r <= acc_result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_pm1_standard   = out_res_r.pm1_standard;
  assign out_pm25_std       = out_res_r.pm25_std;
  assign out_pm10_std       = out_res_r.pm10_std;
  assign out_received_check = out_res_r.received_check;
  assign out_expected_check = out_res_r.expected_check;

  // A frame-closing byte always yields a result in the next cycle.
  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load_result |=> out_valid_r)
    else $error("frame end did not produce a result");

  // The input only stalls behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall && acc_last))
    else $error("input stalled without a blocked result");

  // An ok verdict means the checksums agree.
  a_ok_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.status != ST_OK ||
                     out_res_r.received_check == out_res_r.expected_check))
    else $error("ok verdict with mismatched checksum");

endmodule

`default_nettype wire
